// ----- src/pet_pkg.sv -----
// Shared types and constants of the pointer event throttle.
// Used by every module of the block and by the port checker; depends on nothing.
package pet_pkg;

  // field widths
  localparam int unsigned CoordW    = 20;
  localparam int unsigned StampW    = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned PendW     = 5;
  localparam int unsigned ThreshW   = 12;
  localparam int unsigned ActionW   = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // squared distance: two squares of 21 bit differences
  localparam int unsigned DistW     = 2 * CoordW + 2;
  localparam int unsigned ThrSqW    = 2 * ThreshW;

  // one drain emits at most this many words
  localparam int unsigned MaxResults = 16;

  // command queue between front and back, power of two
  localparam int unsigned CmdDepth   = 2;
  localparam int unsigned ResultDepth = MaxResults;

  // reset values of the registers
  localparam logic [IntervalW-1:0] ResetInterval  = 16'd16;
  localparam logic [PendW-1:0]     ResetMaxPend   = 5'd10;
  localparam logic [ThreshW-1:0]   ResetThreshold = 12'd16;

  // input actions
  typedef enum logic [ActionW-1:0] {
    ACT_POINT = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_CLEAR = 2'd3
  } act_e;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL    = 2'd0,
    CFG_MAX_PENDING = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ActionW-1:0]       action;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic [StampW-1:0]        out_stamp;
    logic                     last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    act_e   kind;
    point_t pt;
  } cmd_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [StampW-1:0]        stamp;
  } entry_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval;
    logic [PendW-1:0]     max_pending;
    logic [ThreshW-1:0]   threshold;
  } cfg_t;

  typedef struct packed {
    logic   start;
    point_t a;
    point_t b;
  } dist_req_t;

endpackage

// ----- src/pet_fifo.sv -----
// Result queue of the pointer event throttle: holds emitted words until popped.
// Depends on pet_pkg for the word type and depth.
module pet_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  pet_pkg::out_item_t  data_i,
  output logic                empty_o,
  input  logic                pop_i,
  output pet_pkg::out_item_t  data_o
);
  localparam int unsigned PtrW = $clog2(pet_pkg::ResultDepth);
  localparam int unsigned CntW = $clog2(pet_pkg::ResultDepth + 1);

  pet_pkg::out_item_t mem_q [pet_pkg::ResultDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(pet_pkg::ResultDepth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) wr_q <= wr_q + PtrW'(1);
      if (pop_ok)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(push_ok) - CntW'(pop_ok);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- src/pet_front.sv -----
// Front end of the pointer event throttle: takes input words, decodes the action
// and holds them in a short command queue for the back end. Depends on pet_pkg.
module pet_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  pet_pkg::in_item_t  item_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output pet_pkg::cmd_t      cmd_o
);
  localparam int unsigned PtrW = $clog2(pet_pkg::CmdDepth);
  localparam int unsigned CntW = $clog2(pet_pkg::CmdDepth + 1);

  pet_pkg::cmd_t   slot_q [pet_pkg::CmdDepth];
  pet_pkg::cmd_t   dec;
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push_ok, pop_ok;

  assign full_o      = (cnt_q == CntW'(pet_pkg::CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push_ok     = push_i & ~full_o;
  assign pop_ok      = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = slot_q[rd_q];

  // decode: only a point carries coordinates
  always_comb begin
    dec.kind = pet_pkg::act_e'(item_i.action);
    dec.pt   = '0;
    unique case (dec.kind)
      pet_pkg::ACT_POINT: begin
        dec.pt.x = item_i.pos_x;
        dec.pt.y = item_i.pos_y;
      end
      pet_pkg::ACT_TICK, pet_pkg::ACT_FLUSH, pet_pkg::ACT_CLEAR: begin
        dec.pt = '0;
      end
    endcase
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) wr_q <= wr_q + PtrW'(1);
      if (pop_ok)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(push_ok) - CntW'(pop_ok);
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (push_ok) slot_q[wr_q] <= dec;
  end

endmodule

// ----- src/pet_dist.sv -----
// Squared distance unit of the pointer event throttle: difference, square, sum,
// one register stage each. Depends on pet_pkg.
module pet_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pet_pkg::dist_req_t          req_i,
  output logic                        valid_o,
  output logic [pet_pkg::DistW-1:0]   d2_o
);
  localparam int unsigned DiffW = pet_pkg::CoordW + 1;

  logic signed [DiffW-1:0]          dx_q, dy_q;
  logic signed [pet_pkg::DistW-1:0] sx_q, sy_q;
  logic [pet_pkg::DistW-1:0]        d2_q;
  logic [2:0]                       vld_q;

  assign valid_o = vld_q[2];
  assign d2_o    = d2_q;

  // valid follows the data down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], req_i.start};
    end
  end

  // difference, square, sum
  always_ff @(posedge clk_i) begin
    dx_q <= {req_i.a.x[pet_pkg::CoordW-1], req_i.a.x} - {req_i.b.x[pet_pkg::CoordW-1], req_i.b.x};
    dy_q <= {req_i.a.y[pet_pkg::CoordW-1], req_i.a.y} - {req_i.b.y[pet_pkg::CoordW-1], req_i.b.y};
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
    d2_q <= $unsigned(sx_q) + $unsigned(sy_q);
  end

endmodule

// ----- src/pet_core.sv -----
// Back end of the pointer event throttle: millisecond time, one-shot timer, the
// point queue and the drain walk. Depends on pet_pkg and pet_dist.
module pet_core #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pet_pkg::cfg_t       cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  pet_pkg::cmd_t       cmd_i,
  output logic                res_push_o,
  input  logic                res_full_i,
  output pet_pkg::out_item_t  res_o
);
  localparam int unsigned IdxW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned LimCap = (QueueDepth < pet_pkg::MaxResults) ?
                                   QueueDepth : pet_pkg::MaxResults;
  localparam int unsigned DistW  = pet_pkg::DistW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCEPT,
    S_ENQ,
    S_CUR,
    S_NXT,
    S_DWAIT,
    S_EMIT
  } state_e;

  // circular position base + off
  function automatic logic [IdxW-1:0] slot_at(input logic [IdxW-1:0] base,
                                              input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(QueueDepth)) sum = sum - SumW'(QueueDepth);
    return IdxW'(sum);
  endfunction

  state_e                          state_q, state_d;
  logic [IdxW-1:0]                 head_q, head_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [CntW-1:0]                 idx_q, idx_d;
  pet_pkg::entry_t                 last_q, last_d;
  logic [pet_pkg::StampW-1:0]      now_q, now_d;
  logic [pet_pkg::IntervalW-1:0]   left_q, left_d;
  logic                            running_q, running_d;
  logic                            near_q, near_d;
  logic                            final_q, final_d;
  pet_pkg::point_t                 pt_q, pt_d;
  pet_pkg::entry_t                 cur_q, cur_d;
  logic [IdxW-1:0]                 rd_addr_q, rd_addr_d;
  pet_pkg::entry_t                 rd_data_q;
  logic [pet_pkg::ThrSqW-1:0]      thr_sq_q;

  pet_pkg::entry_t                 mem_q [QueueDepth];
  logic                            wr_en;
  pet_pkg::entry_t                 wr_entry;

  pet_pkg::dist_req_t              dist_req;
  logic                            dist_valid;
  logic [DistW-1:0]                d2;

  logic [pet_pkg::IntervalW-1:0]   ivl_eff, left_dec;
  logic [pet_pkg::IntervalW-2:0]   half_ivl;
  logic [pet_pkg::StampW-1:0]      elapsed;
  logic [pet_pkg::PendW-1:0]       mp_eff;
  logic [CntW-1:0]                 lim;
  logic [DistW-1:0]                t1, t4, t9;
  logic                            enq_full;
  logic [CntW-1:0]                 enq_c1, enq_c2;
  logic [IdxW-1:0]                 enq_h1, enq_addr;

  // effective interval, limit and thresholds
  assign ivl_eff  = (cfg_i.interval == '0) ? pet_pkg::IntervalW'(1) : cfg_i.interval;
  assign half_ivl = ivl_eff[pet_pkg::IntervalW-1:1];
  assign elapsed  = now_q - last_q.stamp;
  assign left_dec = (left_q != '0) ? left_q - pet_pkg::IntervalW'(1) : '0;
  assign mp_eff   = (cfg_i.max_pending == '0) ? pet_pkg::PendW'(1) : cfg_i.max_pending;
  assign lim      = (6'(mp_eff) > 6'(LimCap)) ? CntW'(LimCap) : CntW'(mp_eff);
  assign t1       = DistW'(thr_sq_q);
  assign t4       = DistW'({thr_sq_q, 2'b00});
  assign t9       = DistW'({thr_sq_q, 3'b000}) + DistW'(thr_sq_q);

  // enqueue positions: make room at the hard depth, write, then trim to the limit
  assign enq_full = (count_q >= CntW'(QueueDepth));
  assign enq_c1   = enq_full ? count_q - CntW'(1) : count_q;
  assign enq_h1   = enq_full ? slot_at(head_q, CntW'(1)) : head_q;
  assign enq_addr = slot_at(enq_h1, enq_c1);
  assign enq_c2   = enq_c1 + CntW'(1);

  assign res_o.out_x       = cur_q.x;
  assign res_o.out_y       = cur_q.y;
  assign res_o.out_stamp   = cur_q.stamp;
  assign res_o.last_of_run = final_q;

  pet_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dist_req),
    .valid_o (dist_valid),
    .d2_o    (d2)
  );

  // command sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_d      = last_q;
    now_d       = now_q;
    left_d      = left_q;
    running_d   = running_q;
    near_d      = near_q;
    final_d     = final_q;
    pt_d        = pt_q;
    cur_d       = cur_q;
    rd_addr_d   = rd_addr_q;
    cmd_ready_o = 1'b0;
    res_push_o  = 1'b0;
    wr_en       = 1'b0;
    wr_entry.x     = pt_q.x;
    wr_entry.y     = pt_q.y;
    wr_entry.stamp = now_q;
    dist_req.start = 1'b0;
    dist_req.a.x   = last_q.x;
    dist_req.a.y   = last_q.y;
    dist_req.b     = cmd_i.pt;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            pet_pkg::ACT_POINT: begin
              pt_d   = cmd_i.pt;
              near_d = (elapsed < pet_pkg::StampW'(half_ivl));
              if (last_q.stamp == '0) begin
                state_d = S_ENQ;
              end else begin
                dist_req.start = 1'b1;
                state_d        = S_ACCEPT;
              end
            end
            pet_pkg::ACT_TICK: begin
              now_d = now_q + pet_pkg::StampW'(1);
              if (running_q) begin
                left_d = left_dec;
                if (left_dec == '0) begin
                  running_d = 1'b0;
                  idx_d     = '0;
                  rd_addr_d = head_q;
                  if (count_q != '0) state_d = S_CUR;
                end
              end
            end
            pet_pkg::ACT_FLUSH: begin
              running_d = 1'b0;
              left_d    = '0;
              idx_d     = '0;
              rd_addr_d = head_q;
              if (count_q != '0) state_d = S_CUR;
            end
            pet_pkg::ACT_CLEAR: begin
              count_d   = '0;
              running_d = 1'b0;
              left_d    = '0;
            end
          endcase
        end
      end

      // movement test against the last drained point
      S_ACCEPT: begin
        if (dist_valid) begin
          if (near_q ? (d2 > t9) : (d2 > t1)) state_d = S_ENQ;
          else                                state_d = S_IDLE;
        end
      end

      S_ENQ: begin
        wr_en = 1'b1;
        if (enq_c2 > lim) begin
          head_d  = slot_at(enq_h1, enq_c2 - lim);
          count_d = lim;
        end else begin
          head_d  = enq_h1;
          count_d = enq_c2;
        end
        if (!running_q) begin
          running_d = 1'b1;
          left_d    = ivl_eff;
        end
        state_d = S_IDLE;
      end

      // entry idx is on the read port; fetch its successor unless it is the last
      S_CUR: begin
        cur_d = rd_data_q;
        if (idx_q + CntW'(1) == count_q) begin
          final_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          final_d   = 1'b0;
          rd_addr_d = slot_at(head_q, idx_q + CntW'(1));
          state_d   = S_NXT;
        end
      end

      S_NXT: begin
        dist_req.start = 1'b1;
        dist_req.a.x   = cur_q.x;
        dist_req.a.y   = cur_q.y;
        dist_req.b.x   = rd_data_q.x;
        dist_req.b.y   = rd_data_q.y;
        state_d        = S_DWAIT;
      end

      // keep the point only if it is far from its successor
      S_DWAIT: begin
        if (dist_valid) begin
          if (d2 > t4) begin
            state_d = S_EMIT;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_CUR;
          end
        end
      end

      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          last_d     = cur_q;
          if (final_q) begin
            head_d  = slot_at(head_q, count_q);
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_CUR;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      last_q    <= '0;
      now_q     <= '0;
      left_q    <= '0;
      running_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      last_q    <= last_d;
      now_q     <= now_d;
      left_q    <= left_d;
      running_q <= running_d;
      rd_addr_q <= rd_addr_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    near_q   <= near_d;
    final_q  <= final_d;
    pt_q     <= pt_d;
    cur_q    <= cur_d;
    thr_sq_q <= pet_pkg::ThrSqW'(cfg_i.threshold) * pet_pkg::ThrSqW'(cfg_i.threshold);
  end

  // point queue memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[enq_addr] <= wr_entry;
    rd_data_q <= mem_q[rd_addr_d];
  end

endmodule

// ----- src/pointer_event_throttle.sv -----
// Top level of the pointer event throttle: registers, front end, back end, result queue.
// Depends on pet_pkg, pet_front, pet_core and pet_fifo.
//
// Decimates pointer positions. Each input word is a point, a millisecond tick, a
// flush or a clear; points that moved far enough from the last drained point are
// queued with the current time, and a timer expiry or a flush drains the queue
// into the result side, keeping a point only if it lies more than twice the
// threshold from its successor and always keeping the final one (marked by
// last_of_run). Input words wait in a two-entry command queue, so push is taken
// while the back end works. A point is tested by the three-stage squared-distance
// unit, and skips the test while the last drained stamp is zero; a drain walks the
// queue through the single read port of the point memory and the same distance
// unit, and it stalls while the 16-word result queue is full. Registers may be
// written only while the block is idle.
module pointer_event_throttle #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  pet_pkg::in_item_t                 in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output pet_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pet_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pet_pkg::CfgDataW-1:0]      cfg_data_i
);
  pet_pkg::cfg_t      cfg_q;
  pet_pkg::cmd_t      cmd;
  logic               cmd_valid, cmd_ready;
  pet_pkg::out_item_t res;
  logic               res_push, res_full;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval    <= pet_pkg::ResetInterval;
      cfg_q.max_pending <= pet_pkg::ResetMaxPend;
      cfg_q.threshold   <= pet_pkg::ResetThreshold;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pet_pkg::cfg_idx_e'(cfg_index_i))
        pet_pkg::CFG_INTERVAL:    cfg_q.interval    <= cfg_data_i;
        pet_pkg::CFG_MAX_PENDING: cfg_q.max_pending <= cfg_data_i[pet_pkg::PendW-1:0];
        pet_pkg::CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i[pet_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  pet_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pet_core #(
    .QueueDepth (QueueDepth)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res)
  );

  pet_fifo u_results (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (out_item_o)
  );

endmodule

// ----- src/pet_checker.sv -----
// Port checker of the pointer event throttle and its bind to the top level.
// Depends on pet_pkg and pointer_event_throttle.
module pet_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input pet_pkg::out_item_t out_item_o
);

  // a waiting result word stays put until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result word changed while waiting");

  // input side fills only through push
  a_full_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // result side drains only through pop
  a_empty_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("empty rose without a pop");

  // out of reset nothing is queued on either side
  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (empty && !full))
    else $error("queues not clear after reset");

endmodule

bind pointer_event_throttle pet_port_checker u_checker (.*);
